@@ rtl/sem_pkg.sv @@
// Shared types and constants for the Sobel edge magnitude block.
// Used by the lanes, the merge stage and the top level; depends on nothing.
`default_nettype none
package sem_pkg;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int CFG_IW         = 2;
    localparam int CFG_DW         = 11;
    localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam int ROOT_STEPS     = 11;
    localparam logic [7:0] MAG_MAX = 8'd255;

    // 3x3 window of one channel, [row][col]
    typedef logic [2:0][2:0][7:0] t_win;
    typedef logic [2:0][7:0] t_rgb;
endpackage
`default_nettype wire

@@ rtl/sem_lane.sv @@
// One channel lane: Sobel gradients, squared sum and rounded integer root.
// Uses sem_pkg for the window type and root step count.
`default_nettype none
module sem_lane (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire sem_pkg::t_win i_win,
    output logic               o_done,
    output logic [7:0]         o_mag
);
    localparam logic [1:0] LS_IDLE = 2'd0;
    localparam logic [1:0] LS_SUM  = 2'd1;
    localparam logic [1:0] LS_ROOT = 2'd2;
    localparam logic [1:0] LS_FIN  = 2'd3;

    logic [1:0]         r_state;
    logic [3:0]         r_cnt;
    logic signed [11:0] r_gx, r_gy;
    logic [21:0]        r_s;
    logic [11:0]        r_rem;
    logic [10:0]        r_q;
    logic               r_done;
    logic [7:0]         r_mag;

    logic signed [11:0] n_gx, n_gy;
    logic [9:0]         ax, ay;
    logic [20:0]        sq_sum;
    logic [13:0]        trial, tsub;
    logic [11:0]        rounded;

    function automatic logic signed [11:0] px(input logic [7:0] v);
        px = signed'({4'b0, v});
    endfunction

    // gradients from the padded window
    always_comb begin
        n_gx = (px(i_win[0][2]) + 12'sd2 * px(i_win[1][2]) + px(i_win[2][2]))
             - (px(i_win[0][0]) + 12'sd2 * px(i_win[1][0]) + px(i_win[2][0]));
        n_gy = (px(i_win[2][0]) + 12'sd2 * px(i_win[2][1]) + px(i_win[2][2]))
             - (px(i_win[0][0]) + 12'sd2 * px(i_win[0][1]) + px(i_win[0][2]));
    end

    // magnitudes and squared sum
    always_comb begin
        ax = r_gx[11] ? 10'(-r_gx) : r_gx[9:0];
        ay = r_gy[11] ? 10'(-r_gy) : r_gy[9:0];
        sq_sum = 21'({10'b0, ax} * {10'b0, ax}) + 21'({10'b0, ay} * {10'b0, ay});
    end

    // one root digit per step
    always_comb begin
        trial = {r_rem, r_s[21:20]};
        tsub  = {1'b0, r_q, 2'b01};
        rounded = {1'b0, r_q} + ((r_rem > {1'b0, r_q}) ? 12'd1 : 12'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LS_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                LS_IDLE: begin
                    if (i_start) begin
                        r_gx    <= n_gx;
                        r_gy    <= n_gy;
                        r_done  <= 1'b0;
                        r_state <= LS_SUM;
                    end
                end
                LS_SUM: begin
                    r_s     <= {1'b0, sq_sum};
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_cnt   <= 4'(sem_pkg::ROOT_STEPS - 1);
                    r_state <= LS_ROOT;
                end
                LS_ROOT: begin
                    if (trial >= tsub) begin
                        r_rem <= 12'(trial - tsub);
                        r_q   <= {r_q[9:0], 1'b1};
                    end else begin
                        r_rem <= trial[11:0];
                        r_q   <= {r_q[9:0], 1'b0};
                    end
                    r_s <= {r_s[19:0], 2'b00};
                    if (r_cnt == 4'd0) begin
                        r_state <= LS_FIN;
                    end else begin
                        r_cnt <= r_cnt - 4'd1;
                    end
                end
                LS_FIN: begin
                    // round up past f*f+f, then saturate
                    r_mag   <= (rounded > 12'(sem_pkg::MAG_MAX)) ? sem_pkg::MAG_MAX
                                                                  : rounded[7:0];
                    r_done  <= 1'b1;
                    r_state <= LS_IDLE;
                end
                default: r_state <= LS_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_mag  = r_mag;
endmodule
`default_nettype wire

@@ rtl/sem_merge.sv @@
// Merge stage: gathers the three lane results with coordinates into the
// output register. Uses sem_pkg for the RGB type.
`default_nettype none
module sem_merge (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [2:0]    i_lane_done,
    input  wire logic          i_pending,
    input  wire sem_pkg::t_rgb i_mag,
    input  wire logic [9:0]    i_row,
    input  wire logic [9:0]    i_col,
    input  wire logic          i_last,
    input  wire logic          i_stall,
    output logic               o_load,
    output logic               o_valid,
    output logic [7:0]         o_red_edge,
    output logic [7:0]         o_green_edge,
    output logic [7:0]         o_blue_edge,
    output logic [9:0]         o_out_row,
    output logic [9:0]         o_out_col,
    output logic               o_frame_done
);
    logic r_valid;

    // load when every lane is finished and the register is free
    assign o_load = i_pending && (&i_lane_done) && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            o_red_edge   <= i_mag[0];
            o_green_edge <= i_mag[1];
            o_blue_edge  <= i_mag[2];
            o_out_row    <= i_row;
            o_out_col    <= i_col;
            o_frame_done <= i_last;
        end
    end

    assign o_valid = r_valid;
endmodule
`default_nettype wire

@@ rtl/sobel_edge_magnitude_rgb.sv @@
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_op, i_red_in, i_green_in, i_blue_in
// output    out        o_valid / i_stall    edges, o_out_row, o_out_col, o_frame_done
// config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// A result item passes the load state, each lane's sum, 11-step digit root and
// final states and the merge load; the next item is taken after that load. One
// that yields none passes only the load state; an ignored drain stays idle.
// Synchronous active-low reset clears counters, taps and the output valid;
// the line store needs no clearing. A stalled output keeps its request while
// the next item is accepted.
// Top level: line store, window taps, counters and three channel lanes.
// Depends on sem_pkg, sem_lane and sem_merge.
`default_nettype none
module sobel_edge_magnitude_rgb #(
    parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic                       i_op,
    input  wire logic [7:0]                 i_red_in,
    input  wire logic [7:0]                 i_green_in,
    input  wire logic [7:0]                 i_blue_in,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [7:0]                      o_red_edge,
    output logic [7:0]                      o_green_edge,
    output logic [7:0]                      o_blue_edge,
    output logic [9:0]                      o_out_row,
    output logic [9:0]                      o_out_col,
    output logic                            o_frame_done,
    input  wire logic                       i_cfg_we,
    input  wire logic [sem_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [sem_pkg::CFG_DW-1:0] i_cfg_data
);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int AW = $clog2(MAX_WIDTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;

    logic [1:0]    r_state;
    logic [CW-1:0] r_w, r_col, r_oc;
    logic [RW-1:0] r_h, r_row, r_or;
    logic [23:0]   r_tap [3][3];
    logic [47:0]   mem [MAX_WIDTH];
    logic [47:0]   r_rd;
    logic [AW-1:0] r_addr;
    logic [23:0]   r_pix;
    logic          r_emit, r_last;
    logic [3:0]    r_pad;
    logic [9:0]    r_mrow, r_mcol;

    logic          accept, input_done, ignore, emit, last;
    logic [CW-1:0] col_n, oc_n;
    logic [RW-1:0] or_n;
    logic [10:0]   cfg_v;
    logic [23:0]   entering [3];
    logic [23:0]   n_tap [3][3];
    sem_pkg::t_win win [3];
    logic [2:0]    lane_done;
    sem_pkg::t_rgb mag;
    logic          load;
    logic [RW+9:0] row_ext;
    logic [CW+9:0] col_ext;

    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && !o_stall;

    // classify the request and advance positions
    always_comb begin
        input_done = (r_row >= r_h);
        ignore     = !input_done && i_op;
        emit       = !((r_row == '0) || ((r_row == RW'(1)) && (r_col == '0)));
        col_n      = r_col + CW'(1);
        oc_n       = r_oc + CW'(1);
        or_n       = r_or + RW'(1);
        last       = (oc_n == r_w) && (or_n == r_h);
        cfg_v      = (i_cfg_data == '0) ? 11'd1 : i_cfg_data;
        row_ext    = {10'b0, r_or};
        col_ext    = {10'b0, r_oc};
    end

    // next taps and padded windows, one per lane
    always_comb begin
        entering[0] = r_rd[47:24];
        entering[1] = r_rd[23:0];
        entering[2] = r_pix;
        for (int k = 0; k < 3; k++) begin
            n_tap[k][0] = r_tap[k][1];
            n_tap[k][1] = r_tap[k][2];
            n_tap[k][2] = entering[k];
        end
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if ((i == 0 && r_pad[0]) || (i == 2 && r_pad[1])
                        || (j == 0 && r_pad[2]) || (j == 2 && r_pad[3])) begin
                        win[ch][i][j] = 8'd0;
                    end else begin
                        win[ch][i][j] = n_tap[i][j][16 - 8 * ch +: 8];
                    end
                end
            end
        end
    end

    // line store: read on acceptance, write back in the load state
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= mem[r_col[AW-1:0]];
        end
        if (r_state == ST_LOAD) begin
            mem[r_addr] <= {r_rd[23:0], r_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= r_col[AW-1:0];
            r_pix  <= input_done ? 24'd0 : {i_red_in, i_green_in, i_blue_in};
            r_emit <= emit;
            r_last <= last;
            r_mrow <= row_ext[9:0];
            r_mcol <= col_ext[9:0];
            r_pad  <= {oc_n >= r_w, r_oc == '0, or_n >= r_h, r_or == '0};
        end
    end

    // control: state, counters, taps, configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_w     <= CW'(MAX_WIDTH);
            r_h     <= RW'(MAX_HEIGHT);
            r_row   <= '0;
            r_col   <= '0;
            r_or    <= '0;
            r_oc    <= '0;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_tap[k][j] <= '0;
                end
            end
        end else if (i_cfg_we && (i_cfg_index == sem_pkg::REG_FRAME_WIDTH
                                  || i_cfg_index == sem_pkg::REG_FRAME_HEIGHT)) begin
            if (i_cfg_index == sem_pkg::REG_FRAME_WIDTH) begin
                r_w <= (32'(cfg_v) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(cfg_v);
            end else begin
                r_h <= (32'(cfg_v) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(cfg_v);
            end
            r_row <= '0;
            r_col <= '0;
            r_or  <= '0;
            r_oc  <= '0;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_tap[k][j] <= '0;
                end
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept && !ignore) begin
                        r_state <= ST_LOAD;
                        if (col_n >= r_w) begin
                            r_col <= '0;
                            r_row <= r_row + RW'(1);
                        end else begin
                            r_col <= col_n;
                        end
                        if (emit) begin
                            if (last) begin
                                r_row <= '0;
                                r_col <= '0;
                                r_or  <= '0;
                                r_oc  <= '0;
                            end else if (oc_n >= r_w) begin
                                r_oc <= '0;
                                r_or <= or_n;
                            end else begin
                                r_oc <= oc_n;
                            end
                        end
                    end
                end
                ST_LOAD: begin
                    for (int k = 0; k < 3; k++) begin
                        for (int j = 0; j < 3; j++) begin
                            r_tap[k][j] <= n_tap[k][j];
                        end
                    end
                    r_state <= r_emit ? ST_CALC : ST_IDLE;
                end
                ST_CALC: begin
                    if (load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // three channel lanes side by side
    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        sem_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start ((r_state == ST_LOAD) && r_emit),
            .i_win   (win[ch]),
            .o_done  (lane_done[ch]),
            .o_mag   (mag[ch])
        );
    end

    sem_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_lane_done  (lane_done),
        .i_pending    (r_state == ST_CALC),
        .i_mag        (mag),
        .i_row        (r_mrow),
        .i_col        (r_mcol),
        .i_last       (r_last),
        .i_stall      (i_stall),
        .o_load       (load),
        .o_valid      (o_valid),
        .o_red_edge   (o_red_edge),
        .o_green_edge (o_green_edge),
        .o_blue_edge  (o_blue_edge),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_frame_done (o_frame_done)
    );
endmodule
`default_nettype wire

@@ rtl/sem_checker.sv @@
// Port-level checks for the Sobel edge magnitude block, bound to the top.
// Depends only on the clock, reset, handshake, i_op and i_cfg_we ports of sobel_edge_magnitude_rgb.
`default_nettype none
module sem_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_stall,
    input wire logic i_op,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire logic i_cfg_we
);
    // hold a stalled result request
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output request dropped while stalled");

    // reset clears the output request
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // an accepted pixel with no config write makes the block busy next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_op && !i_cfg_we |=> o_stall)
        else $error("pixel accepted without going busy");

    // a new result never appears without an earlier stalled input side
    a_new_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared while input side idle");
endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (.*);
`default_nettype wire

@@ tb/sobel_edge_magnitude_rgb_test.sv @@
// Self-checking testbench for sobel_edge_magnitude_rgb: directed and random frames.
// Holds its own Sobel magnitude predictor and compares every output request with it.
// Depends on sem_pkg and the sobel_edge_magnitude_rgb RTL.
`timescale 1ns / 100ps
`default_nettype none
module sobel_edge_magnitude_rgb_test;
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;
    localparam logic [sem_pkg::CFG_IW-1:0] REG_UNUSED = 2'd3;
    localparam int LINE_DEPTH = 1024;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 30;
    localparam int RANDOM_ITEMS = 250;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } t_edge_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic i_op;
    logic [7:0] i_red_in, i_green_in, i_blue_in;
    logic o_valid;
    logic i_stall;
    logic [7:0] o_red_edge, o_green_edge, o_blue_edge;
    logic [9:0] o_out_row, o_out_col;
    logic o_frame_done;
    logic i_cfg_we;
    logic [sem_pkg::CFG_IW-1:0] i_cfg_index;
    logic [sem_pkg::CFG_DW-1:0] i_cfg_data;

    sobel_edge_magnitude_rgb dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    int unsigned frm_w, frm_h;
    logic [23:0] upper_store [LINE_DEPTH];
    logic [23:0] middle_store [LINE_DEPTH];
    logic [23:0] taps [3][3];
    int unsigned row_in, col_in, out_count;
    t_edge_result pending_edges[$];

    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    int unsigned items_sent = 0;
    bit quiet = 1'b0;
    int unsigned stall_left = 0;

    function automatic int unsigned gap_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] edge_magnitude(int p[3][3]);
        int gx, gy, s, f;
        gx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
        gy = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
        s = gx * gx + gy * gy;
        f = 0;
        while ((f + 1) * (f + 1) <= s) f++;
        if (s > f * f + f) f++;
        return (f > 255) ? sem_pkg::MAG_MAX : f[7:0];
    endfunction

    function automatic void restart_frame();
        foreach (taps[k, j]) taps[k][j] = '0;
        row_in = 0;
        col_in = 0;
        out_count = 0;
    endfunction

    function automatic void predict_config(logic [sem_pkg::CFG_IW-1:0] idx,
                                           logic [sem_pkg::CFG_DW-1:0] val);
        int unsigned v;
        v = (val == 0) ? 1 : val;
        if (idx == sem_pkg::REG_FRAME_WIDTH) frm_w = (v > LINE_DEPTH) ? LINE_DEPTH : v;
        else if (idx == sem_pkg::REG_FRAME_HEIGHT) frm_h = (v > LINE_DEPTH) ? LINE_DEPTH : v;
        else return;
        restart_frame();
    endfunction

    // work out the output request, if any, caused by one accepted input
    function automatic void predict_edges(logic op, logic [7:0] r, logic [7:0] g,
                                          logic [7:0] b);
        logic [23:0] pix, entering[3];
        int unsigned col, n, rr, cc;
        int p[3][3];
        t_edge_result res;
        logic [7:0] mag[3];
        pix = '0;
        if (row_in < frm_h) begin
            if (op == OP_DRAIN) return;
            pix = {r, g, b};
        end else if (out_count >= frm_w * frm_h) begin
            return;
        end
        col = col_in;
        entering[0] = upper_store[col];
        entering[1] = middle_store[col];
        entering[2] = pix;
        upper_store[col] = middle_store[col];
        middle_store[col] = pix;
        for (int k = 0; k < 3; k++) begin
            taps[k][0] = taps[k][1];
            taps[k][1] = taps[k][2];
            taps[k][2] = entering[k];
        end
        n = row_in * frm_w + col_in;
        col_in++;
        if (col_in >= frm_w) begin
            col_in = 0;
            row_in++;
        end
        if (n < frm_w + 1) return;
        rr = out_count / frm_w;
        cc = out_count % frm_w;
        out_count++;
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if ((i == 0 && rr == 0) || (i == 2 && rr + 1 >= frm_h) ||
                        (j == 0 && cc == 0) || (j == 2 && cc + 1 >= frm_w))
                        p[i][j] = 0;
                    else
                        p[i][j] = (taps[i][j] >> (16 - 8 * ch)) & 8'hFF;
                end
            end
            mag[ch] = edge_magnitude(p);
        end
        res.red = mag[0];
        res.green = mag[1];
        res.blue = mag[2];
        res.row = rr[9:0];
        res.col = cc[9:0];
        res.last = 1'b0;
        if (out_count >= frm_w * frm_h) begin
            res.last = 1'b1;
            row_in = 0;
            col_in = 0;
            out_count = 0;
        end
        pending_edges.push_back(res);
    endfunction

    // hold one request until accepted, then an optional gap
    task automatic send_item(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned gap;
        i_valid <= 1'b1;
        i_op <= op;
        i_red_in <= r;
        i_green_in <= g;
        i_blue_in <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_edges(op, r, g, b);
        items_sent++;
        gap = gap_length();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_pixel();
        send_item(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // wait until every expected result is out and the pipe has settled
    task automatic drain_wait();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_edges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [sem_pkg::CFG_IW-1:0] idx,
                             logic [sem_pkg::CFG_DW-1:0] val);
        drain_wait();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        predict_config(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // one full frame with optional ignored drains mixed in, then the flush
    task automatic run_frame(int unsigned noise_pct);
        int unsigned total;
        total = frm_w * frm_h;
        for (int unsigned i = 0; i < total; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
            send_pixel();
        end
        for (int unsigned i = 0; i <= frm_w; i++)
            send_item(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                      8'($urandom));
    endtask

    task automatic test_directed();
        logic [7:0] v;
        write_reg(sem_pkg::REG_FRAME_WIDTH, 11'd3);
        write_reg(sem_pkg::REG_FRAME_HEIGHT, 11'd3);
        // drain while frame incomplete is dropped
        send_item(OP_DRAIN, 8'hFF, 8'h00, 8'hFF);
        for (int i = 0; i < 9; i++) begin
            v = (i % 2) ? 8'hFF : 8'h00;
            send_item(OP_PIXEL, v, ~v, (i == 4) ? 8'hFF : 8'h00);
        end
        // a pixel after input completion acts as a drain
        send_item(OP_PIXEL, 8'hAA, 8'h55, 8'hFF);
        for (int i = 0; i < 3; i++) send_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
        // zero saturates to one
        write_reg(sem_pkg::REG_FRAME_WIDTH, 11'd0);
        write_reg(sem_pkg::REG_FRAME_HEIGHT, 11'd0);
        send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
        send_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
        // unknown index is ignored
        write_reg(REG_UNUSED, 11'h7FF);
        send_item(OP_PIXEL, 8'h12, 8'h34, 8'h56);
        send_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
        send_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_wide_frame();
        write_reg(sem_pkg::REG_FRAME_WIDTH, 11'd160);
        write_reg(sem_pkg::REG_FRAME_HEIGHT, 11'd1);
        run_frame(0);
    endtask

    task automatic test_tall_frame();
        write_reg(sem_pkg::REG_FRAME_WIDTH, 11'd1);
        // height beyond the maximum frame height saturates to that maximum
        write_reg(sem_pkg::REG_FRAME_HEIGHT, 11'h7FF);
        run_frame(2);
    endtask

    task automatic test_random_frames();
        int unsigned start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0)
                write_reg(sem_pkg::REG_FRAME_WIDTH, 11'($urandom_range(1, 12)));
            if ($urandom_range(0, 2) == 0)
                write_reg(sem_pkg::REG_FRAME_HEIGHT, 11'($urandom_range(1, 8)));
            if ($urandom_range(0, 9) == 0)
                write_reg(2'($urandom_range(2, 3)), 11'($urandom));
            run_frame($urandom_range(0, 8));
        end
        quiet = 1'b0;
    endtask

    // output stall: random gaps, with quiet stretches
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (quiet || $urandom_range(0, 99) < 65) begin
            i_stall <= 1'b0;
        end else begin
            stall_left <= gap_length();
            i_stall <= 1'b1;
        end
    end

    // compare each accepted output with the oldest expectation
    always @(posedge i_clk) begin
        t_edge_result got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_red_edge, o_green_edge, o_blue_edge, o_out_row, o_out_col, o_frame_done};
            if (pending_edges.size() == 0) begin
                if (mismatches < 10) $display("unexpected output %p", got);
                mismatches++;
            end else begin
                want = pending_edges.pop_front();
                if (got !== want) begin
                    if (mismatches < 10) $display("mismatch: expected %p got %p", want, got);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted request on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_op <= OP_PIXEL;
        i_red_in <= '0;
        i_green_in <= '0;
        i_blue_in <= '0;
        i_stall <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= sem_pkg::REG_FRAME_WIDTH;
        i_cfg_data <= '0;
        frm_w = LINE_DEPTH;
        frm_h = LINE_DEPTH;
        foreach (upper_store[i]) begin
            upper_store[i] = '0;
            middle_store[i] = '0;
        end
        restart_frame();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_wide_frame();
        test_tall_frame();
        test_random_frames();
        drain_wait();
        if (mismatches == 0 && pending_edges.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ sobel_edge_magnitude_rgb.f @@
rtl/sem_pkg.sv
rtl/sem_lane.sv
rtl/sem_merge.sv
rtl/sobel_edge_magnitude_rgb.sv
rtl/sem_checker.sv
tb/sobel_edge_magnitude_rgb_test.sv
